/* rtl/srdz_pkg.sv */
// Shared widths, constants and types for the radial dead zone scaler.
package srdz_pkg;

    localparam int STICK_W    = 16;
    localparam int BYTE_W     = 8;
    localparam int PCT_W      = 7;
    localparam int SQ_W       = 32;
    localparam int MAG_W      = 16;
    localparam int DZ_W       = 15;
    localparam int NUM_W      = 31;
    localparam int SCALE_W    = 16;
    localparam int SQRT_STEPS = MAG_W;
    localparam int SDIV_STEPS = 15;
    localparam int ODIV_STEPS = BYTE_W;
    localparam int PROD_W     = 31;
    localparam int DEN_W      = MAG_W + 8;

    localparam logic [PCT_W-1:0]   PCT_MAX    = 7'd99;
    // 32768/100 scaled by 2^16 and rounded up; exact floor for every percent up to 99.
    localparam logic [24:0]        DZ_MULT    = 25'd21474837;
    localparam logic [DZ_W-1:0]    FULL_SCALE = 15'd32767;
    localparam logic [SCALE_W-1:0] SCALE_CAP  = 16'd32768;
    localparam logic [BYTE_W-1:0]  CENTRE     = 8'd128;

    typedef logic signed [STICK_W-1:0] stick_t;
    typedef logic [BYTE_W-1:0]         byte_t;
    typedef logic [PCT_W-1:0]          pct_t;

endpackage

/* rtl/srdz_if.sv */
// Valid/ready channel interfaces for stick samples, result bytes and configuration.
interface srdz_in_if
    import srdz_pkg::*;
();
    logic   valid;
    logic   ready;
    stick_t stick_x;
    stick_t stick_y;
    modport source (output valid, output stick_x, output stick_y, input ready);
    modport sink   (input valid, input stick_x, input stick_y, output ready);
endinterface

interface srdz_out_if
    import srdz_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t byte_x;
    byte_t byte_y;
    modport source (output valid, output byte_x, output byte_y, input ready);
    modport sink   (input valid, input byte_x, input byte_y, output ready);
endinterface

interface srdz_cfg_if
    import srdz_pkg::*;
();
    logic valid;
    logic ready;
    pct_t deadzone_percent;
    modport source (output valid, output deadzone_percent, input ready);
    modport sink   (input valid, input deadzone_percent, output ready);
endinterface

/* rtl/stick_radial_deadzone_scaler.sv */
// Radial dead zone scaler: stick position in, two centered bytes out.
// The block accepts one stick sample per clock while its output is not stalled.
// The pipeline has 45 register stages: 16 for the square root, 15 for
// the dead zone rescaling divider, 8 for the divider on each axis, and six more for the
// input, sum of squares, numerator, saturation check, products and output. The whole
// pipeline holds when a finished result is not taken, and moves again without losing a beat.
// Dead zone writes take effect on the next clock and should only be made while the
// pipeline is empty.
module stick_radial_deadzone_scaler
    import srdz_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    srdz_in_if.sink    stick,
    srdz_out_if.source result,
    srdz_cfg_if.sink   cfg
);

    logic adv;

    // Configuration: dead zone radius and rescaling divisor.
    logic [DZ_W-1:0] dz_reg, dz_next;
    logic [DZ_W-1:0] den_reg, den_next;
    pct_t            pct_sat;
    logic [31:0]     dz_prod;

    always_comb
    begin
        pct_sat  = (cfg.deadzone_percent > PCT_MAX) ? PCT_MAX : cfg.deadzone_percent;
        dz_prod  = 32'(pct_sat) * 32'(DZ_MULT);
        dz_next  = dz_prod[30:16];
        den_next = FULL_SCALE - dz_next;
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg  <= '0;
            den_reg <= FULL_SCALE;
        end
        else if (cfg.valid)
        begin
            dz_reg  <= dz_next;
            den_reg <= den_next;
        end
    end

    // Input register and sum of squares.
    logic   in_v_reg, sq_v_reg;
    stick_t in_x_reg, in_y_reg, sq_x_reg, sq_y_reg;
    logic [SQ_W-1:0] sq_reg;

    // Square root, one result bit per stage.
    logic [SQRT_STEPS-1:0] rt_v_reg;
    logic [17:0]           rt_rem_reg  [SQRT_STEPS];
    logic [MAG_W-1:0]      rt_root_reg [SQRT_STEPS];
    logic [SQ_W-1:0]       rt_n_reg    [SQRT_STEPS];
    stick_t                rt_x_reg    [SQRT_STEPS];
    stick_t                rt_y_reg    [SQRT_STEPS];
    logic [17:0]           rt_rem_next [SQRT_STEPS];
    logic [MAG_W-1:0]      rt_root_next[SQRT_STEPS];
    logic [19:0]           rt_sh       [SQRT_STEPS];
    logic [19:0]           rt_trial    [SQRT_STEPS];
    logic [17:0]           rt_prem     [SQRT_STEPS];
    logic [MAG_W-1:0]      rt_proot    [SQRT_STEPS];
    logic [SQ_W-1:0]       rt_pn       [SQRT_STEPS];

    // Rescaling numerator.
    logic             a_v_reg, a_zf_reg;
    logic [NUM_W-1:0] a_num_reg;
    logic [MAG_W-1:0] a_mag_reg;
    stick_t           a_x_reg, a_y_reg;
    logic [MAG_W-1:0] mag;
    logic [MAG_W:0]   mag_diff;
    logic [NUM_W-1:0] num_next;
    logic             zf_next;

    // Saturation check before the rescaling divider.
    logic             b_v_reg, b_zf_reg, b_sat_reg;
    logic [NUM_W-1:0] b_num_reg;
    logic [MAG_W-1:0] b_mag_reg;
    stick_t           b_x_reg, b_y_reg;

    // Rescaling divider, one quotient bit per stage.
    logic [SDIV_STEPS-1:0] sd_v_reg, sd_zf_reg, sd_sat_reg;
    logic [NUM_W-1:0]      sd_rem_reg [SDIV_STEPS];
    logic [SDIV_STEPS-1:0] sd_q_reg   [SDIV_STEPS];
    logic [MAG_W-1:0]      sd_mag_reg [SDIV_STEPS];
    stick_t                sd_x_reg   [SDIV_STEPS];
    stick_t                sd_y_reg   [SDIV_STEPS];
    logic [NUM_W-1:0]      sd_rem_next[SDIV_STEPS];
    logic [SDIV_STEPS-1:0] sd_q_next  [SDIV_STEPS];
    logic [NUM_W-1:0]      sd_prem    [SDIV_STEPS];
    logic [SDIV_STEPS-1:0] sd_pq      [SDIV_STEPS];
    logic [NUM_W-1:0]      sd_trial   [SDIV_STEPS];

    // Products of each axis with the scaled radius.
    logic               p_v_reg, p_sz_reg, p_xn_reg, p_yn_reg;
    logic [PROD_W-1:0]  p_px_reg, p_py_reg;
    logic [DEN_W-1:0]   p_den_reg;
    logic [SCALE_W-1:0] scale;
    logic [STICK_W-1:0] abs_x, abs_y;

    // Per-axis dividers, one quotient bit per stage.
    logic [ODIV_STEPS-1:0] od_v_reg, od_sz_reg, od_xn_reg, od_yn_reg;
    logic [PROD_W-1:0]     od_rx_reg  [ODIV_STEPS];
    logic [PROD_W-1:0]     od_ry_reg  [ODIV_STEPS];
    logic [BYTE_W-1:0]     od_qx_reg  [ODIV_STEPS];
    logic [BYTE_W-1:0]     od_qy_reg  [ODIV_STEPS];
    logic [DEN_W-1:0]      od_den_reg [ODIV_STEPS];
    logic [PROD_W-1:0]     od_rx_next [ODIV_STEPS];
    logic [PROD_W-1:0]     od_ry_next [ODIV_STEPS];
    logic [BYTE_W-1:0]     od_qx_next [ODIV_STEPS];
    logic [BYTE_W-1:0]     od_qy_next [ODIV_STEPS];
    logic [PROD_W-1:0]     od_prx     [ODIV_STEPS];
    logic [PROD_W-1:0]     od_pry     [ODIV_STEPS];
    logic [BYTE_W-1:0]     od_pqx     [ODIV_STEPS];
    logic [BYTE_W-1:0]     od_pqy     [ODIV_STEPS];
    logic [DEN_W-1:0]      od_pden    [ODIV_STEPS];
    logic [31:0]           od_trial   [ODIV_STEPS];

    // Output register.
    logic  out_v_reg;
    byte_t out_x_reg, out_y_reg, out_x_next, out_y_next;
    logic  fx_nz, fy_nz;
    logic signed [9:0] fx_val, fy_val;

    function automatic byte_t clamp_byte(input logic signed [9:0] v);
        if (v < 10'sd0)
            return '0;
        else if (v > 10'sd255)
            return 8'd255;
        else
            return v[7:0];
    endfunction

    assign adv           = !out_v_reg || result.ready;
    assign stick.ready   = adv;
    assign result.valid  = out_v_reg;
    assign result.byte_x = out_x_reg;
    assign result.byte_y = out_y_reg;

    // Square root steps: bring down two bits, try subtracting 4*root+1.
    always_comb
    begin
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            if (k == 0)
            begin
                rt_prem[k]  = '0;
                rt_proot[k] = '0;
                rt_pn[k]    = sq_reg;
            end
            else
            begin
                rt_prem[k]  = rt_rem_reg[k-1];
                rt_proot[k] = rt_root_reg[k-1];
                rt_pn[k]    = rt_n_reg[k-1];
            end
            rt_sh[k]    = {rt_prem[k], rt_pn[k][SQ_W-1 -: 2]};
            rt_trial[k] = {2'b00, rt_proot[k], 2'b01};
            if (rt_sh[k] >= rt_trial[k])
            begin
                rt_rem_next[k]  = 18'(rt_sh[k] - rt_trial[k]);
                rt_root_next[k] = {rt_proot[k][MAG_W-2:0], 1'b1};
            end
            else
            begin
                rt_rem_next[k]  = rt_sh[k][17:0];
                rt_root_next[k] = {rt_proot[k][MAG_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        mag      = rt_root_reg[SQRT_STEPS-1];
        mag_diff = {1'b0, mag} - {2'b00, dz_reg};
        zf_next  = (mag == '0) || mag_diff[MAG_W];
        // (mag - dz) * 32767 as a shift and subtract.
        num_next = zf_next ? '0
                 : ({mag_diff[MAG_W-1:0], 15'b0} - NUM_W'(mag_diff[MAG_W-1:0]));
    end

    always_comb
    begin
        for (int j = 0; j < SDIV_STEPS; j++)
        begin
            if (j == 0)
            begin
                sd_prem[j] = b_num_reg;
                sd_pq[j]   = '0;
            end
            else
            begin
                sd_prem[j] = sd_rem_reg[j-1];
                sd_pq[j]   = sd_q_reg[j-1];
            end
            sd_trial[j] = NUM_W'(den_reg) << (SDIV_STEPS - 1 - j);
            if (sd_prem[j] >= sd_trial[j])
            begin
                sd_rem_next[j] = sd_prem[j] - sd_trial[j];
                sd_q_next[j]   = sd_pq[j] | (SDIV_STEPS'(1) << (SDIV_STEPS - 1 - j));
            end
            else
            begin
                sd_rem_next[j] = sd_prem[j];
                sd_q_next[j]   = sd_pq[j];
            end
        end
    end

    always_comb
    begin
        if (sd_zf_reg[SDIV_STEPS-1])
            scale = '0;
        else if (sd_sat_reg[SDIV_STEPS-1])
            scale = SCALE_CAP;
        else
            scale = SCALE_W'(sd_q_reg[SDIV_STEPS-1]);
        abs_x = sd_x_reg[SDIV_STEPS-1][STICK_W-1] ? STICK_W'(-sd_x_reg[SDIV_STEPS-1])
                                                  : STICK_W'(sd_x_reg[SDIV_STEPS-1]);
        abs_y = sd_y_reg[SDIV_STEPS-1][STICK_W-1] ? STICK_W'(-sd_y_reg[SDIV_STEPS-1])
                                                  : STICK_W'(sd_y_reg[SDIV_STEPS-1]);
    end

    always_comb
    begin
        for (int i = 0; i < ODIV_STEPS; i++)
        begin
            if (i == 0)
            begin
                od_prx[i]  = p_px_reg;
                od_pry[i]  = p_py_reg;
                od_pqx[i]  = '0;
                od_pqy[i]  = '0;
                od_pden[i] = p_den_reg;
            end
            else
            begin
                od_prx[i]  = od_rx_reg[i-1];
                od_pry[i]  = od_ry_reg[i-1];
                od_pqx[i]  = od_qx_reg[i-1];
                od_pqy[i]  = od_qy_reg[i-1];
                od_pden[i] = od_den_reg[i-1];
            end
            od_trial[i] = 32'(od_pden[i]) << (ODIV_STEPS - 1 - i);
            if (32'(od_prx[i]) >= od_trial[i])
            begin
                od_rx_next[i] = PROD_W'(32'(od_prx[i]) - od_trial[i]);
                od_qx_next[i] = od_pqx[i] | (BYTE_W'(1) << (ODIV_STEPS - 1 - i));
            end
            else
            begin
                od_rx_next[i] = od_prx[i];
                od_qx_next[i] = od_pqx[i];
            end
            if (32'(od_pry[i]) >= od_trial[i])
            begin
                od_ry_next[i] = PROD_W'(32'(od_pry[i]) - od_trial[i]);
                od_qy_next[i] = od_pqy[i] | (BYTE_W'(1) << (ODIV_STEPS - 1 - i));
            end
            else
            begin
                od_ry_next[i] = od_pry[i];
                od_qy_next[i] = od_pqy[i];
            end
        end
    end

    // Floor for x, ceiling for y, then y is mirrored about the center.
    always_comb
    begin
        fx_nz = od_rx_reg[ODIV_STEPS-1] != '0;
        fy_nz = od_ry_reg[ODIV_STEPS-1] != '0;
        if (od_xn_reg[ODIV_STEPS-1])
            fx_val = 10'sd128 - 10'(od_qx_reg[ODIV_STEPS-1]) - 10'(fx_nz);
        else
            fx_val = 10'sd128 + 10'(od_qx_reg[ODIV_STEPS-1]);
        if (od_yn_reg[ODIV_STEPS-1])
            fy_val = 10'sd128 + 10'(od_qy_reg[ODIV_STEPS-1]);
        else
            fy_val = 10'sd128 - 10'(od_qy_reg[ODIV_STEPS-1]) - 10'(fy_nz);
        if (od_sz_reg[ODIV_STEPS-1])
        begin
            out_x_next = CENTRE;
            out_y_next = CENTRE;
        end
        else
        begin
            out_x_next = clamp_byte(fx_val);
            out_y_next = clamp_byte(fy_val);
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            sq_v_reg  <= 1'b0;
            rt_v_reg  <= '0;
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            sd_v_reg  <= '0;
            p_v_reg   <= 1'b0;
            od_v_reg  <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_v_reg  <= stick.valid;
            sq_v_reg  <= in_v_reg;
            rt_v_reg  <= {rt_v_reg[SQRT_STEPS-2:0], sq_v_reg};
            a_v_reg   <= rt_v_reg[SQRT_STEPS-1];
            b_v_reg   <= a_v_reg;
            sd_v_reg  <= {sd_v_reg[SDIV_STEPS-2:0], b_v_reg};
            p_v_reg   <= sd_v_reg[SDIV_STEPS-1];
            od_v_reg  <= {od_v_reg[ODIV_STEPS-2:0], p_v_reg};
            out_v_reg <= od_v_reg[ODIV_STEPS-1];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_x_reg <= stick.stick_x;
            in_y_reg <= stick.stick_y;

            sq_reg   <= SQ_W'(in_x_reg * in_x_reg) + SQ_W'(in_y_reg * in_y_reg);
            sq_x_reg <= in_x_reg;
            sq_y_reg <= in_y_reg;

            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                rt_rem_reg[k]  <= rt_rem_next[k];
                rt_root_reg[k] <= rt_root_next[k];
                rt_n_reg[k]    <= {rt_pn[k][SQ_W-3:0], 2'b00};
                rt_x_reg[k]    <= (k == 0) ? sq_x_reg : rt_x_reg[k-1];
                rt_y_reg[k]    <= (k == 0) ? sq_y_reg : rt_y_reg[k-1];
            end

            a_num_reg <= num_next;
            a_zf_reg  <= zf_next;
            a_mag_reg <= mag;
            a_x_reg   <= rt_x_reg[SQRT_STEPS-1];
            a_y_reg   <= rt_y_reg[SQRT_STEPS-1];

            b_num_reg <= a_num_reg;
            b_zf_reg  <= a_zf_reg;
            b_sat_reg <= a_num_reg >= {den_reg, 15'b0};
            b_mag_reg <= a_mag_reg;
            b_x_reg   <= a_x_reg;
            b_y_reg   <= a_y_reg;

            for (int j = 0; j < SDIV_STEPS; j++)
            begin
                sd_rem_reg[j] <= sd_rem_next[j];
                sd_q_reg[j]   <= sd_q_next[j];
                sd_zf_reg[j]  <= (j == 0) ? b_zf_reg  : sd_zf_reg[j-1];
                sd_sat_reg[j] <= (j == 0) ? b_sat_reg : sd_sat_reg[j-1];
                sd_mag_reg[j] <= (j == 0) ? b_mag_reg : sd_mag_reg[j-1];
                sd_x_reg[j]   <= (j == 0) ? b_x_reg   : sd_x_reg[j-1];
                sd_y_reg[j]   <= (j == 0) ? b_y_reg   : sd_y_reg[j-1];
            end

            p_px_reg  <= PROD_W'(32'(abs_x) * 32'(scale));
            p_py_reg  <= PROD_W'(32'(abs_y) * 32'(scale));
            p_den_reg <= {sd_mag_reg[SDIV_STEPS-1], 8'b0};
            p_sz_reg  <= scale == '0;
            p_xn_reg  <= sd_x_reg[SDIV_STEPS-1][STICK_W-1];
            p_yn_reg  <= sd_y_reg[SDIV_STEPS-1][STICK_W-1];

            for (int i = 0; i < ODIV_STEPS; i++)
            begin
                od_rx_reg[i]  <= od_rx_next[i];
                od_ry_reg[i]  <= od_ry_next[i];
                od_qx_reg[i]  <= od_qx_next[i];
                od_qy_reg[i]  <= od_qy_next[i];
                od_den_reg[i] <= od_pden[i];
                od_sz_reg[i]  <= (i == 0) ? p_sz_reg : od_sz_reg[i-1];
                od_xn_reg[i]  <= (i == 0) ? p_xn_reg : od_xn_reg[i-1];
                od_yn_reg[i]  <= (i == 0) ? p_yn_reg : od_yn_reg[i-1];
            end

            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
        end
    end

endmodule

/* rtl/srdz_checker.sv */
// Port-level assertions for the radial dead zone scaler and their binding.
module srdz_checker
    import srdz_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  stick_valid,
    input logic  stick_ready,
    input logic  result_valid,
    input logic  result_ready,
    input byte_t byte_x,
    input byte_t byte_y,
    input logic  cfg_valid,
    input logic  cfg_ready
);

    // A result beat that is not taken stays put.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(byte_x) && $stable(byte_y))
        else $error("stalled result beat changed");

    // The pipeline takes a sample exactly when its output is free to move.
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        stick_ready == (!result_valid || result_ready))
        else $error("input ready does not track output stall");

    // Configuration writes are never back-pressured.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind stick_radial_deadzone_scaler srdz_checker u_srdz_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .stick_valid  (stick.valid),
    .stick_ready  (stick.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .byte_x       (result.byte_x),
    .byte_y       (result.byte_y),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready)
);
